[rtl/core/sbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants for the serial byte master with clock acknowledge.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int TICK_W     = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_HALF     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_HALF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULLDOWN_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TMO  = 3'd4;

  // register reset values
  localparam logic [15:0] LOW_HALF_DEFAULT     = 16'd19;
  localparam logic [15:0] HIGH_HALF_DEFAULT    = 16'd16;
  localparam logic [7:0]  POST_RELEASE_DEFAULT = 8'd3;
  localparam logic [15:0] PULLDOWN_LIM_DEFAULT = 16'd100;
  localparam logic [23:0] RELEASE_TMO_DEFAULT  = 24'd100000;

  // completion status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_PULLDOWN_TO = 2'd1;
  localparam logic [1:0] STATUS_RELEASE_TO  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LOW     = 3'd1,
    PH_HIGH    = 3'd2,
    PH_POST    = 3'd3,
    PH_PULL    = 3'd4,
    PH_REL     = 3'd5,
    PH_EXPIRED = 3'd6
  } phase_t;

  typedef struct packed {
    logic [15:0] low_half_ticks;
    logic [15:0] high_half_ticks;
    logic [7:0]  post_release_ticks;
    logic [15:0] pulldown_limit;
    logic [23:0] release_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       clk_drive_en;
    logic       clk_level;
    logic       mosi_level;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_byte;
  } res_t;

endpackage

[rtl/core/sbm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_core
// Per-tick bit engine: phase, bit and tick counters, shift registers, and the
// pin levels and completion result for the current tick.
// ----------------------------------------------------------------------------
module sbm_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  sbm_pkg::cfg_t cfg,
  input  logic          start_req,
  input  logic [7:0]    tx_byte,
  input  logic          clk_line_in,
  input  logic          miso_in,
  output sbm_pkg::res_t res
);

  sbm_pkg::phase_t             phase_r, phase_nxt;
  logic [2:0]                  bit_idx_r, bit_idx_nxt;
  logic [sbm_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic [7:0]                  tx_shift_r, tx_shift_nxt;
  logic [7:0]                  rx_shift_r, rx_shift_nxt;

  logic [15:0] low_eff;
  logic [15:0] high_eff;

  // a zero half period behaves as one tick
  assign low_eff  = (cfg.low_half_ticks == 16'd0) ? 16'd1 : cfg.low_half_ticks;
  assign high_eff = (cfg.high_half_ticks == 16'd0) ? 16'd1 : cfg.high_half_ticks;

  always_comb begin
    phase_nxt    = phase_r;
    bit_idx_nxt  = bit_idx_r;
    tick_nxt     = tick_r;
    tx_shift_nxt = tx_shift_r;
    rx_shift_nxt = rx_shift_r;

    res              = '0;
    res.clk_level    = 1'b1;
    res.mosi_level   = 1'b1;
    res.busy_res     = 1'b1;
    res.status       = sbm_pkg::STATUS_OK;

    if (!(phase_r inside {sbm_pkg::PH_LOW, sbm_pkg::PH_HIGH, sbm_pkg::PH_POST,
                          sbm_pkg::PH_PULL, sbm_pkg::PH_REL, sbm_pkg::PH_EXPIRED})) begin
      phase_nxt = sbm_pkg::PH_IDLE;
      if (start_req) begin
        // the start tick is already the first low tick
        tx_shift_nxt = tx_byte;
        rx_shift_nxt = 8'd0;
        bit_idx_nxt  = 3'd0;
        tick_nxt     = '0;
        phase_nxt    = sbm_pkg::PH_LOW;
      end else begin
        res.busy_res = 1'b0;
      end
    end

    case (phase_nxt)
      sbm_pkg::PH_LOW: begin
        res.clk_drive_en = 1'b1;
        res.clk_level    = 1'b0;
        res.mosi_level   = tx_shift_nxt[7];
        tick_nxt         = tick_nxt + 24'd1;
        if (tick_nxt >= {8'd0, low_eff}) begin
          phase_nxt = sbm_pkg::PH_HIGH;
          tick_nxt  = '0;
        end
      end
      sbm_pkg::PH_HIGH: begin
        res.clk_drive_en = 1'b1;
        res.clk_level    = 1'b1;
        res.mosi_level   = tx_shift_nxt[7];
        if (tick_nxt == '0) begin
          rx_shift_nxt = {rx_shift_nxt[6:0], miso_in};
        end
        tick_nxt = tick_nxt + 24'd1;
        if (tick_nxt >= {8'd0, high_eff}) begin
          tick_nxt = '0;
          if (bit_idx_nxt == 3'd7) begin
            phase_nxt = (cfg.post_release_ticks != 8'd0) ? sbm_pkg::PH_POST
                                                         : sbm_pkg::PH_PULL;
          end else begin
            bit_idx_nxt  = bit_idx_nxt + 3'd1;
            tx_shift_nxt = {tx_shift_nxt[6:0], 1'b0};
            phase_nxt    = sbm_pkg::PH_LOW;
          end
        end
      end
      sbm_pkg::PH_POST: begin
        // clock released, last data bit still held
        res.mosi_level = tx_shift_nxt[7];
        tick_nxt       = tick_nxt + 24'd1;
        if (tick_nxt >= {16'd0, cfg.post_release_ticks}) begin
          phase_nxt = sbm_pkg::PH_PULL;
          tick_nxt  = '0;
        end
      end
      sbm_pkg::PH_PULL: begin
        if (!clk_line_in) begin
          phase_nxt = sbm_pkg::PH_REL;
          tick_nxt  = '0;
        end else if (tick_nxt > {8'd0, cfg.pulldown_limit}) begin
          res.done_res = 1'b1;
          res.status   = sbm_pkg::STATUS_PULLDOWN_TO;
        end else begin
          tick_nxt = tick_nxt + 24'd1;
        end
      end
      sbm_pkg::PH_REL: begin
        if (clk_line_in) begin
          res.done_res = 1'b1;
          res.status   = sbm_pkg::STATUS_OK;
          res.rx_byte  = rx_shift_nxt;
        end else if (tick_nxt >= cfg.release_timeout_ticks) begin
          phase_nxt = sbm_pkg::PH_EXPIRED;
        end else begin
          tick_nxt = tick_nxt + 24'd1;
        end
      end
      sbm_pkg::PH_EXPIRED: begin
        res.done_res = 1'b1;
        res.status   = sbm_pkg::STATUS_RELEASE_TO;
      end
      default: begin
      end
    endcase

    if (res.done_res) begin
      res.busy_res = 1'b0;
      phase_nxt    = sbm_pkg::PH_IDLE;
      tick_nxt     = '0;
      bit_idx_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sbm_pkg::PH_IDLE;
      bit_idx_r  <= 3'd0;
      tick_r     <= '0;
      tx_shift_r <= 8'd0;
      rx_shift_r <= 8'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      bit_idx_r  <= bit_idx_nxt;
      tick_r     <= tick_nxt;
      tx_shift_r <= tx_shift_nxt;
      rx_shift_r <= rx_shift_nxt;
    end
  end

endmodule

[rtl/core/serial_byte_master_with_clock_ack_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_byte_master_with_clock_ack_unit
// Tick-driven serial byte master, MSB first, idle clock high, with a clock
// pull-down / release acknowledge from the partner and two timeouts.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_valid / in_stall  | start_req, tx_byte, clk_line_in,
//          |     |                      | miso_in (one tick per request)
//  out_    | out | out_valid / out_stall| pin levels, busy, done, status, rx
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
//  One request per cycle while in_stall is low; its result is registered.
//  A two-entry output buffer (head plus skid) sits on the result side, so
//  in_stall rises only when both entries are full and is itself a register.
//  Reset clears the bit engine to idle and loads the timing register defaults.
//  User writes timing registers only while the engine is idle (not enforced).
// ----------------------------------------------------------------------------
module serial_byte_master_with_clock_ack_unit (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_start_req,
  input  logic [7:0]                       in_tx_byte,
  input  logic                             in_clk_line_in,
  input  logic                             in_miso_in,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_clk_drive_en,
  output logic                             out_clk_level,
  output logic                             out_mosi_level,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic [1:0]                       out_status,
  output logic [7:0]                       out_rx_byte,

  input  logic                             cfg_we,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  sbm_pkg::cfg_t cfg_r;
  sbm_pkg::res_t step_res;
  sbm_pkg::res_t head_r, head_nxt;
  sbm_pkg::res_t skid_r, skid_nxt;
  logic          head_valid_r, head_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  logic          accept;
  logic          pop;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid & ~skid_valid_r;
  assign out_valid = head_valid_r;
  assign pop       = head_valid_r & ~out_stall;

  // timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_half_ticks        <= sbm_pkg::LOW_HALF_DEFAULT;
      cfg_r.high_half_ticks       <= sbm_pkg::HIGH_HALF_DEFAULT;
      cfg_r.post_release_ticks    <= sbm_pkg::POST_RELEASE_DEFAULT;
      cfg_r.pulldown_limit        <= sbm_pkg::PULLDOWN_LIM_DEFAULT;
      cfg_r.release_timeout_ticks <= sbm_pkg::RELEASE_TMO_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        sbm_pkg::CFG_LOW_HALF:     cfg_r.low_half_ticks        <= cfg_wdata[15:0];
        sbm_pkg::CFG_HIGH_HALF:    cfg_r.high_half_ticks       <= cfg_wdata[15:0];
        sbm_pkg::CFG_POST_RELEASE: cfg_r.post_release_ticks    <= cfg_wdata[7:0];
        sbm_pkg::CFG_PULLDOWN_LIM: cfg_r.pulldown_limit        <= cfg_wdata[15:0];
        sbm_pkg::CFG_RELEASE_TMO:  cfg_r.release_timeout_ticks <= cfg_wdata[23:0];
        default: begin
        end
      endcase
    end
  end

  sbm_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .cfg         (cfg_r),
    .start_req   (in_start_req),
    .tx_byte     (in_tx_byte),
    .clk_line_in (in_clk_line_in),
    .miso_in     (in_miso_in),
    .res         (step_res)
  );

  // two-entry output buffer
  always_comb begin
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        head_valid_nxt = 1'b0;
      end
    end
    if (accept) begin
      if (!head_valid_nxt) begin
        head_valid_nxt = 1'b1;
        head_nxt       = step_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = step_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_clk_drive_en = head_r.clk_drive_en;
  assign out_clk_level    = head_r.clk_level;
  assign out_mosi_level   = head_r.mosi_level;
  assign out_busy_res     = head_r.busy_res;
  assign out_done_res     = head_r.done_res;
  assign out_status       = head_r.status;
  assign out_rx_byte      = head_r.rx_byte;

`ifndef SYNTH
  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry held without head entry");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && head_valid_r && !pop) |=> skid_valid_r)
    else $error("request lost with head entry blocked");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_res && out_busy_res))
    else $error("done and busy both set");

  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_status == sbm_pkg::STATUS_OK))
    else $error("status reported without done");

  a_rx_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rx_byte != 8'd0)) |->
      (out_done_res && (out_status == sbm_pkg::STATUS_OK)))
    else $error("received byte shown outside a good completion");
`endif

endmodule

[tb/tb_serial_byte_master_with_clock_ack_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_byte_master_with_clock_ack_unit
// Drives tick requests into the serial byte master and compares every
// returned tick result, field by field, against an in-bench model of the bit
// engine or a typed result. A short table of hand-picked ticks comes first.
// Random traffic follows, with a partner that pulls and releases the clock
// line on schedule or too late. The timing registers are reprogrammed
// between traffic phases. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_serial_byte_master_with_clock_ack_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int N_DIR          = 21;
  localparam int N_TIMING       = 8;

  localparam sbm_pkg::res_t IDLE_RES = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                                         sbm_pkg::STATUS_OK, 8'h00};
  localparam sbm_pkg::res_t RTO_RES  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                                         sbm_pkg::STATUS_RELEASE_TO, 8'h00};

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_start_req = 1'b0;
  logic [7:0]                     in_tx_byte = 8'h00;
  logic                           in_clk_line_in = 1'b1;
  logic                           in_miso_in = 1'b0;
  logic                           out_stall = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [sbm_pkg::CFG_IDX_W-1:0]  cfg_index = sbm_pkg::CFG_LOW_HALF;
  logic [sbm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic       in_stall;
  logic       out_valid;
  logic       out_clk_drive_en;
  logic       out_clk_level;
  logic       out_mosi_level;
  logic       out_busy_res;
  logic       out_done_res;
  logic [1:0] out_status;
  logic [7:0] out_rx_byte;

  serial_byte_master_with_clock_ack_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_req     (in_start_req),
    .in_tx_byte       (in_tx_byte),
    .in_clk_line_in   (in_clk_line_in),
    .in_miso_in       (in_miso_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_clk_drive_en (out_clk_drive_en),
    .out_clk_level    (out_clk_level),
    .out_mosi_level   (out_mosi_level),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_status       (out_status),
    .out_rx_byte      (out_rx_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bit engine model
  sbm_pkg::cfg_t   shadow_regs;
  sbm_pkg::phase_t eng_phase = sbm_pkg::PH_IDLE;
  logic [2:0]      eng_bit = '0;
  logic [23:0]     eng_ticks = '0;
  logic [7:0]      eng_tx = '0;
  logic [7:0]      eng_rx = '0;

  sbm_pkg::res_t pin_exp_q [$];
  int   mismatches = 0;
  bit   gaps_on = 1'b1;
  int   in_calm = 0;
  int   out_calm = 0;
  int   out_hold = 0;
  int   quiet = 0;
  int   pull_tgt = 0;
  int   hold_tgt = 0;
  sbm_pkg::res_t got, want;

  typedef struct packed {
    logic          st;
    logic [7:0]    tx;
    logic          ck;
    logic          mi;
    logic          typed;
    sbm_pkg::res_t res;
  } dir_row_t;

  typedef struct {
    logic [15:0] low_half;
    logic [15:0] high_half;
    logic [7:0]  post;
    logic [15:0] pull_lim;
    logic [23:0] rel_tmo;
    int          n_req;
    bit          gaps;
    bit          starts;
  } timing_t;

  // zero timing everywhere: one byte, clock pulled, never released in time
  dir_row_t dir_tab [N_DIR] = '{
    '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1, IDLE_RES},
    '{1'b1, 8'h81, 1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 8'hFF, 1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h5A, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 8'hA5, 1'b1, 1'b0, 1'b1, RTO_RES},
    '{1'b0, 8'h3C, 1'b1, 1'b1, 1'b1, IDLE_RES}
  };

  timing_t timing_tab [N_TIMING] = '{
    '{16'd0,     16'd0,     8'd0,   16'd0,     24'd0,        200, 1'b1, 1'b1},
    '{16'd1,     16'd1,     8'd255, 16'd3,     24'd5,        250, 1'b1, 1'b1},
    '{16'd2,     16'd3,     8'd1,   16'd10,    24'd20,       300, 1'b1, 1'b1},
    '{16'd3,     16'd1,     8'd4,   16'd2,     24'd3000,     300, 1'b1, 1'b1},
    '{16'd19,    16'd16,    8'd3,   16'd100,   24'd100000,   300, 1'b1, 1'b1},
    '{16'd1,     16'd2,     8'd0,   16'd65535, 24'd16777215, 150, 1'b0, 1'b1},
    '{16'd65535, 16'd65535, 8'd255, 16'd65535, 24'd16777215, 40,  1'b1, 1'b0},
    '{16'd1,     16'd1,     8'd1,   16'd0,     24'd0,        200, 1'b1, 1'b1}
  };

  function automatic logic [15:0] min_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(15, 50);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // one tick of the bit engine; updates the model state
  task automatic step_bit_engine(input logic st, input logic [7:0] txb, input logic ck,
                                 input logic mi, output sbm_pkg::res_t r);
    logic done;
    r = '0;
    r.clk_level = 1'b1;
    r.mosi_level = 1'b1;
    r.busy_res = 1'b1;
    done = 1'b0;
    if (eng_phase == sbm_pkg::PH_IDLE) begin
      if (st) begin
        eng_tx = txb;
        eng_rx = '0;
        eng_bit = '0;
        eng_ticks = '0;
        eng_phase = sbm_pkg::PH_LOW;
      end else begin
        r.busy_res = 1'b0;
      end
    end
    case (eng_phase)
      sbm_pkg::PH_LOW: begin
        r.clk_drive_en = 1'b1;
        r.clk_level = 1'b0;
        r.mosi_level = eng_tx[7];
        eng_ticks++;
        if (eng_ticks >= min_one(shadow_regs.low_half_ticks)) begin
          eng_phase = sbm_pkg::PH_HIGH;
          eng_ticks = '0;
        end
      end
      sbm_pkg::PH_HIGH: begin
        r.clk_drive_en = 1'b1;
        r.mosi_level = eng_tx[7];
        if (eng_ticks == '0) eng_rx = {eng_rx[6:0], mi};
        eng_ticks++;
        if (eng_ticks >= min_one(shadow_regs.high_half_ticks)) begin
          eng_ticks = '0;
          if (eng_bit == 3'd7) begin
            eng_phase = (shadow_regs.post_release_ticks != 8'd0) ? sbm_pkg::PH_POST
                                                                : sbm_pkg::PH_PULL;
          end else begin
            eng_bit++;
            eng_tx = eng_tx << 1;
            eng_phase = sbm_pkg::PH_LOW;
          end
        end
      end
      sbm_pkg::PH_POST: begin
        r.mosi_level = eng_tx[7];
        eng_ticks++;
        if (eng_ticks >= shadow_regs.post_release_ticks) begin
          eng_phase = sbm_pkg::PH_PULL;
          eng_ticks = '0;
        end
      end
      sbm_pkg::PH_PULL: begin
        if (!ck) begin
          eng_phase = sbm_pkg::PH_REL;
          eng_ticks = '0;
        end else if (eng_ticks > shadow_regs.pulldown_limit) begin
          done = 1'b1;
          r.status = sbm_pkg::STATUS_PULLDOWN_TO;
        end else begin
          eng_ticks++;
        end
      end
      sbm_pkg::PH_REL: begin
        if (ck) begin
          done = 1'b1;
          r.status = sbm_pkg::STATUS_OK;
          r.rx_byte = eng_rx;
        end else if (eng_ticks >= shadow_regs.release_timeout_ticks) begin
          eng_phase = sbm_pkg::PH_EXPIRED;
        end else begin
          eng_ticks++;
        end
      end
      sbm_pkg::PH_EXPIRED: begin
        done = 1'b1;
        r.status = sbm_pkg::STATUS_RELEASE_TO;
      end
      default: ;
    endcase
    if (done) begin
      r.busy_res = 1'b0;
      eng_phase = sbm_pkg::PH_IDLE;
      eng_ticks = '0;
      eng_bit = '0;
    end
    r.done_res = done;
  endtask

  // hand one request to the block and log what it should answer
  task automatic send_tick(input logic st, input logic [7:0] txb, input logic ck,
                           input logic mi, input logic typed,
                           input sbm_pkg::res_t typed_res);
    int gap;
    sbm_pkg::res_t r;
    gap = gaps_on ? draw_wait(in_calm) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= st;
    in_tx_byte <= txb;
    in_clk_line_in <= ck;
    in_miso_in <= mi;
    do @(posedge clk); while (in_stall);
    step_bit_engine(st, txb, ck, mi, r);
    pin_exp_q.push_back(typed ? typed_res : r);
  endtask

  // random request; the partner acks on its own schedule, sometimes too late
  task automatic send_random(input bit starts);
    logic st, ck;
    int lim, tmo;
    st = 1'($urandom_range(0, 1));
    ck = 1'($urandom_range(0, 1));
    lim = int'(shadow_regs.pulldown_limit);
    tmo = int'(shadow_regs.release_timeout_ticks);
    case (eng_phase)
      sbm_pkg::PH_IDLE: begin
        st = starts && ($urandom_range(0, 3) == 0);
        if (st) begin
          case ($urandom_range(0, 9))
            6, 7:    pull_tgt = (lim <= 500) ? lim + 1 : $urandom_range(0, 20);
            8, 9:    pull_tgt = (lim <= 500) ? lim + 2 : $urandom_range(0, 20);
            default: pull_tgt = $urandom_range(0, (lim < 20) ? lim : 20);
          endcase
          case ($urandom_range(0, 9))
            6, 7:    hold_tgt = (tmo <= 500) ? tmo : $urandom_range(0, 12);
            8, 9:    hold_tgt = (tmo <= 500) ? tmo + 1 : $urandom_range(0, 12);
            default: hold_tgt = $urandom_range(0, (tmo < 12) ? tmo : 12);
          endcase
        end
      end
      sbm_pkg::PH_PULL: ck = (eng_ticks >= pull_tgt) ? 1'b0 : 1'b1;
      sbm_pkg::PH_REL:  ck = (eng_ticks >= hold_tgt) ? 1'b1 : 1'b0;
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) ck = 1'($urandom_range(0, 1));
    send_tick(st, 8'($urandom_range(0, 255)), ck, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic write_timing(input timing_t t);
    cfg_we <= 1'b1;
    cfg_index <= sbm_pkg::CFG_LOW_HALF;
    cfg_wdata <= sbm_pkg::CFG_DATA_W'(t.low_half);
    @(posedge clk);
    cfg_index <= sbm_pkg::CFG_HIGH_HALF;
    cfg_wdata <= sbm_pkg::CFG_DATA_W'(t.high_half);
    @(posedge clk);
    cfg_index <= sbm_pkg::CFG_POST_RELEASE;
    cfg_wdata <= sbm_pkg::CFG_DATA_W'(t.post);
    @(posedge clk);
    cfg_index <= sbm_pkg::CFG_PULLDOWN_LIM;
    cfg_wdata <= sbm_pkg::CFG_DATA_W'(t.pull_lim);
    @(posedge clk);
    cfg_index <= sbm_pkg::CFG_RELEASE_TMO;
    cfg_wdata <= t.rel_tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_regs.low_half_ticks = t.low_half;
    shadow_regs.high_half_ticks = t.high_half;
    shadow_regs.post_release_ticks = t.post;
    shadow_regs.pulldown_limit = t.pull_lim;
    shadow_regs.release_timeout_ticks = t.rel_tmo;
  endtask

  task automatic cmp_field(input string fname, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result side: check, then draw the stall for the next result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_clk_drive_en, out_clk_level, out_mosi_level, out_busy_res,
                out_done_res, out_status, out_rx_byte};
        if (pin_exp_q.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          mismatches++;
        end else begin
          want = pin_exp_q.pop_front();
          cmp_field("clk_drive_en", int'(want.clk_drive_en), int'(got.clk_drive_en));
          cmp_field("clk_level", int'(want.clk_level), int'(got.clk_level));
          cmp_field("mosi_level", int'(want.mosi_level), int'(got.mosi_level));
          cmp_field("busy_res", int'(want.busy_res), int'(got.busy_res));
          cmp_field("done_res", int'(want.done_res), int'(got.done_res));
          cmp_field("status", int'(want.status), int'(got.status));
          cmp_field("rx_byte", int'(want.rx_byte), int'(got.rx_byte));
        end
        out_hold = gaps_on ? draw_wait(out_calm) : 0;
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    shadow_regs = '{sbm_pkg::LOW_HALF_DEFAULT, sbm_pkg::HIGH_HALF_DEFAULT,
                    sbm_pkg::POST_RELEASE_DEFAULT, sbm_pkg::PULLDOWN_LIM_DEFAULT,
                    sbm_pkg::RELEASE_TMO_DEFAULT};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < N_TIMING; p++) begin
      write_timing(timing_tab[p]);
      gaps_on = timing_tab[p].gaps;
      if (p == 0) begin
        for (int i = 0; i < N_DIR; i++)
          send_tick(dir_tab[i].st, dir_tab[i].tx, dir_tab[i].ck, dir_tab[i].mi,
                    dir_tab[i].typed, dir_tab[i].res);
      end
      for (int i = 0; i < timing_tab[p].n_req; i++) send_random(timing_tab[p].starts);
      // finish any open transfer: partner pulls, then releases
      while (eng_phase != sbm_pkg::PH_IDLE)
        send_tick(1'b0, 8'($urandom_range(0, 255)),
                  (eng_phase == sbm_pkg::PH_PULL) ? 1'b0 :
                  (eng_phase == sbm_pkg::PH_REL) ? 1'b1 : 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      in_valid <= 1'b0;
      while (pin_exp_q.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
